>>> rtl/core/rzb_pkg.sv
`default_nettype none

package rzb_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned PosW   = 64;
  localparam int unsigned LenW   = 7;
  localparam int unsigned ShW    = 5;
  localparam int unsigned Parts  = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned MinLen = 3;

  localparam logic [CoordW-1:0] All32 = 32'hFFFF_FFFF;
  localparam logic [PosW-1:0]   All64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // One coordinate span, ordered, with its split shift.
  typedef struct packed {
    logic [CoordW-1:0] mn;
    logic [CoordW-1:0] mx;
    logic [ShW-1:0]    sh;
    logic              sp;
  } span_t;

  typedef struct packed {
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [LenW-1:0] len;
  } box_t;

  typedef struct packed {
    rect_t [Parts-1:0] part;
    logic [CntW-1:0]   n;
  } part_set_t;

  typedef struct packed {
    box_t [Parts-1:0] box;
    logic [CntW-1:0]  n;
  } box_set_t;

  typedef struct packed {
    box_t [Parts-1:0] box;
    logic [IdxW-1:0]  last;
  } box_list_t;

  // Highest differing bit plus one, bits below 3 ignored.
  function automatic logic [5:0] len_of32(logic [CoordW-1:0] d);
    logic [5:0] len;
    len = 6'(MinLen);
    for (int i = 3; i < 32; i++) begin
      if (d[i]) len = 6'(i + 1);
    end
    return len;
  endfunction

  function automatic logic [LenW-1:0] len_of64(logic [PosW-1:0] d);
    logic [LenW-1:0] len;
    len = LenW'(MinLen);
    for (int i = 3; i < 64; i++) begin
      if (d[i]) len = LenW'(i + 1);
    end
    return len;
  endfunction

  function automatic logic [PosW-1:0] high_mask(logic [LenW-1:0] len);
    logic [PosW-1:0] m;
    if (len >= LenW'(64)) begin
      m = '0;
    end else begin
      m = All64 << len;
    end
    return m;
  endfunction

  // x bit i to bit 2i, y bit i to bit 2i+1; coordinate bits 0..2 dropped.
  function automatic logic [PosW-1:0] interleave(logic [CoordW-1:0] x,
                                                 logic [CoordW-1:0] y);
    logic [PosW-1:0] r;
    r = '0;
    for (int i = 3; i < 32; i++) begin
      r[2*i]   = x[i];
      r[2*i+1] = y[i];
    end
    return r;
  endfunction

  function automatic span_t make_span(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    span_t s;
    logic  lt;
    lt   = a < b;
    s.mn = lt ? a : b;
    s.mx = lt ? b : a;
    s.sp = a != b;
    s.sh = ShW'(len_of32(a ^ b) - 6'd1);
    return s;
  endfunction

  // True when box a encloses box b.
  function automatic logic box_contains(box_t a, box_t b);
    logic [PosW-1:0] m;
    m = high_mask(a.len);
    return (a.len >= b.len) && (((a.pos ^ b.pos) & m) == '0);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rzb_if.sv
`default_nettype none

interface rzb_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_first;
  logic [31:0] x_second;
  logic [31:0] y_first;
  logic [31:0] y_second;

  modport source (output valid, output x_first, output x_second, output y_first,
                  output y_second, input ready);
  modport sink (input valid, input x_first, input x_second, input y_first,
                input y_second, output ready);
endinterface

interface rzb_box_if;
  logic        valid;
  logic        ready;
  logic [63:0] box_position;
  logic [6:0]  prefix_length;
  logic        last_box;

  modport source (output valid, output box_position, output prefix_length,
                  output last_box, input ready);
  modport sink (input valid, input box_position, input prefix_length,
                input last_box, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rectangle_to_zorder_boxes_top.sv
`default_nettype none

// Rectangle to Z-order prefix boxes. Each request carries two unordered x and
// two unordered y coordinates. The rectangle is cut at most once in x and
// once in y (at the power-of-two pivot under the highest differing bit),
// each piece becomes a Morton prefix box (x on even bits, y on odd bits,
// coordinate bits 0..2 dropped), enclosed boxes are merged away, and the
// survivors leave one per cycle while the sink is ready, with last_box set on
// the final one. A rectangle yields one to four boxes. Requests are accepted
// every cycle while the pipe has room, so a new rectangle flows in while the
// previous one is still being emitted. From request acceptance to the first
// box the data passes two split stages, two box stages, two merge stages and
// the output register. Any stall on the result side backs up through the
// stages without losing or repeating a request.
module rectangle_to_zorder_boxes_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rzb_req_if.sink    req_i,
  rzb_box_if.source  box_o
);
  import rzb_pkg::*;

  // split -> box
  logic      sp_valid, sp_ready;
  part_set_t sp_data;
  // box -> merge
  logic      bx_valid, bx_ready;
  box_set_t  bx_data;
  // merge -> serializer
  logic      mg_valid, mg_ready;
  box_list_t mg_data;
  // request rectangle
  rect_t     req_rect;
  box_t      out_box;
  logic      out_last;

  assign req_rect = '{x0: req_i.x_first, x1: req_i.x_second,
                      y0: req_i.y_first, y1: req_i.y_second};

  // Find the pivots and cut the rectangle into parts.
  rzb_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (req_rect),
    .out_valid_o (sp_valid),
    .out_ready_i (sp_ready),
    .out_data_o  (sp_data)
  );

  // Turn each part into a prefix box.
  rzb_box u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sp_valid),
    .in_ready_o  (sp_ready),
    .in_data_i   (sp_data),
    .out_valid_o (bx_valid),
    .out_ready_i (bx_ready),
    .out_data_o  (bx_data)
  );

  // Drop enclosed boxes, let enclosing ones replace kept entries.
  rzb_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bx_valid),
    .in_ready_o  (bx_ready),
    .in_data_i   (bx_data),
    .out_valid_o (mg_valid),
    .out_ready_i (mg_ready),
    .out_data_o  (mg_data)
  );

  // Emit the kept boxes one per cycle; holds while the sink stalls.
  rzb_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mg_valid),
    .in_ready_o  (mg_ready),
    .in_data_i   (mg_data),
    .out_valid_o (box_o.valid),
    .out_ready_i (box_o.ready),
    .out_box_o   (out_box),
    .out_last_o  (out_last)
  );

  assign box_o.box_position  = out_box.pos;
  assign box_o.prefix_length = out_box.len;
  assign box_o.last_box      = out_last;

endmodule

`default_nettype wire

>>> rtl/core/rzb_split.sv
`default_nettype none

module rzb_split (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rzb_pkg::rect_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rzb_pkg::part_set_t out_data_o
);
  import rzb_pkg::*;

  logic      s1_valid_q, s2_valid_q;
  logic      adv1, adv2;
  span_t     x_span_q, y_span_q;
  part_set_t parts_d, parts_q;

  logic [CoordW-1:0] x_piv, y_piv;
  logic [CoordW-1:0] xl1, yl1;
  rect_t             r00, r01, r10, r11;

  assign adv2       = !s2_valid_q || out_ready_i;
  assign adv1       = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  // Stage 2: cut at the pivots and list the parts in emit order.
  always_comb begin
    x_piv = x_span_q.mx & (All32 << x_span_q.sh);
    y_piv = y_span_q.mx & (All32 << y_span_q.sh);
    // pivot minus one wraps on purpose
    xl1   = x_span_q.sp ? (x_piv - 32'd1) : x_span_q.mx;
    yl1   = y_span_q.sp ? (y_piv - 32'd1) : y_span_q.mx;
    r00   = '{x0: x_span_q.mn, x1: xl1, y0: y_span_q.mn, y1: yl1};
    r01   = '{x0: x_span_q.mn, x1: xl1, y0: y_piv, y1: y_span_q.mx};
    r10   = '{x0: x_piv, x1: x_span_q.mx, y0: y_span_q.mn, y1: yl1};
    r11   = '{x0: x_piv, x1: x_span_q.mx, y0: y_piv, y1: y_span_q.mx};
    parts_d.part[0] = r00;
    parts_d.part[1] = (x_span_q.sp && !y_span_q.sp) ? r10 : r01;
    parts_d.part[2] = r10;
    parts_d.part[3] = r11;
    case ({x_span_q.sp, y_span_q.sp})
      2'b11:   parts_d.n = 3'd4;
      2'b10,
      2'b01:   parts_d.n = 3'd2;
      default: parts_d.n = 3'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      x_span_q <= make_span(in_data_i.x0, in_data_i.x1);
      y_span_q <= make_span(in_data_i.y0, in_data_i.y1);
    end
    if (adv2) parts_q <= parts_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = parts_q;

endmodule

`default_nettype wire

>>> rtl/core/rzb_box.sv
`default_nettype none

module rzb_box (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rzb_pkg::part_set_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rzb_pkg::box_set_t  out_data_o
);
  import rzb_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] lo;
    logic [PosW-1:0] hi;
  } ilv_t;

  logic              s3_valid_q, s4_valid_q;
  logic              adv3, adv4;
  ilv_t [Parts-1:0]  ilv_d, ilv_q;
  logic [CntW-1:0]   n_q;
  box_set_t          boxes_d, boxes_q;

  assign adv4       = !s4_valid_q || out_ready_i;
  assign adv3       = !s3_valid_q || adv4;
  assign in_ready_o = adv3;

  // Stage 3: order the corners and interleave them.
  always_comb begin
    for (int k = 0; k < Parts; k++) begin
      logic [CoordW-1:0] mnx, mxx, mny, mxy;
      mnx = (in_data_i.part[k].x0 < in_data_i.part[k].x1) ? in_data_i.part[k].x0
                                                            : in_data_i.part[k].x1;
      mxx = (in_data_i.part[k].x0 < in_data_i.part[k].x1) ? in_data_i.part[k].x1
                                                            : in_data_i.part[k].x0;
      mny = (in_data_i.part[k].y0 < in_data_i.part[k].y1) ? in_data_i.part[k].y0
                                                            : in_data_i.part[k].y1;
      mxy = (in_data_i.part[k].y0 < in_data_i.part[k].y1) ? in_data_i.part[k].y1
                                                            : in_data_i.part[k].y0;
      ilv_d[k].lo = interleave(mnx, mny);
      ilv_d[k].hi = interleave(mxx, mxy);
    end
  end

  // Stage 4: prefix length and masked position.
  always_comb begin
    for (int k = 0; k < Parts; k++) begin
      boxes_d.box[k].len = len_of64(ilv_q[k].lo ^ ilv_q[k].hi);
      boxes_d.box[k].pos = ilv_q[k].lo & high_mask(boxes_d.box[k].len);
    end
    boxes_d.n = n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (adv3) s3_valid_q <= in_valid_i;
      if (adv4) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      ilv_q <= ilv_d;
      n_q   <= in_data_i.n;
    end
    if (adv4) boxes_q <= boxes_d;
  end

  assign out_valid_o = s4_valid_q;
  assign out_data_o  = boxes_q;

endmodule

`default_nettype wire

>>> rtl/core/rzb_merge.sv
`default_nettype none

module rzb_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rzb_pkg::box_set_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rzb_pkg::box_list_t out_data_o
);
  import rzb_pkg::*;

  logic                        s5_valid_q, s6_valid_q;
  logic                        adv5, adv6;
  logic [Parts-1:0][Parts-1:0] enc_d, enc_q;
  box_set_t                    boxes_q;
  logic [Parts-1:0][IdxW-1:0]  kidx;
  logic [CntW-1:0]             cnt;
  logic                        found;
  box_list_t                   list_d, list_q;

  assign adv6       = !s6_valid_q || out_ready_i;
  assign adv5       = !s5_valid_q || adv6;
  assign in_ready_o = adv5;

  // Stage 5: enc[a][b] set when box a encloses box b.
  always_comb begin
    for (int a = 0; a < Parts; a++) begin
      for (int b = 0; b < Parts; b++) begin
        enc_d[a][b] = box_contains(in_data_i.box[a], in_data_i.box[b]);
      end
    end
  end

  // Stage 6: walk the boxes in order over the kept list, by index.
  always_comb begin
    kidx  = '0;
    cnt   = '0;
    found = 1'b0;
    for (int i = 0; i < Parts; i++) begin
      if (CntW'(i) < boxes_q.n) begin
        found = 1'b0;
        for (int j = 0; j < Parts; j++) begin
          if (CntW'(j) < cnt) begin
            if (enc_q[kidx[j]][i]) begin
              found = 1'b1;
            end else if (enc_q[i][kidx[j]]) begin
              kidx[j] = IdxW'(i);
              found   = 1'b1;
            end
          end
        end
        if (!found) begin
          kidx[cnt[IdxW-1:0]] = IdxW'(i);
          cnt                 = cnt + CntW'(1);
        end
      end
    end
    for (int k = 0; k < Parts; k++) begin
      list_d.box[k] = boxes_q.box[kidx[k]];
    end
    list_d.last = IdxW'(cnt - CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      if (adv5) s5_valid_q <= in_valid_i;
      if (adv6) s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      enc_q   <= enc_d;
      boxes_q <= in_data_i;
    end
    if (adv6) list_q <= list_d;
  end

  assign out_valid_o = s6_valid_q;
  assign out_data_o  = list_q;

endmodule

`default_nettype wire

>>> rtl/core/rzb_serial.sv
`default_nettype none

module rzb_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rzb_pkg::box_list_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rzb_pkg::box_t      out_box_o,
  output logic               out_last_o
);
  import rzb_pkg::*;

  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  box_list_t       list_q;
  logic            take, load, at_last;

  assign at_last    = idx_q == list_q.last;
  assign take       = valid_q && out_ready_i;
  assign in_ready_o = !valid_q || (out_ready_i && at_last);
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) list_q <= in_data_i;
  end

  assign out_valid_o = valid_q;
  assign out_box_o   = list_q.box[idx_q];
  assign out_last_o  = valid_q && at_last;

  a_idx_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= list_q.last)
    else $error("box index beyond kept list");

  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !at_last) |=> (valid_q && idx_q == $past(idx_q) + IdxW'(1)))
    else $error("box index did not advance after a taken box");

  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> $stable(idx_q))
    else $error("box index moved while the output stalled");

endmodule

`default_nettype wire
